// ===== rtl/rrd_pkg.sv =====
package rrd_pkg;

    localparam int RING_BYTES_DEFAULT = 8192;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 13;
    localparam int REL_W      = 13;
    localparam int CNT_W      = 14;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam int HDR_LEN     = 4;
    localparam int REL_BACKOFF = 16;
    // Headroom above the ring size for an unwrapped record end offset.
    localparam int MAX_SPAN_PAD = 8200;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd1600;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECEIVE_ENABLE = 1'b0,
        REG_MAX_RECORD_LEN = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              byte_valid;
        logic              frame_last;
        logic              status_ok;
        logic              size_error;
        logic [REL_W-1:0]  release_offset;
    } rrd_result_t;

endpackage

// ===== rtl/rrd_channels.sv =====
interface rrd_ring_if;
    logic                        valid;
    logic                        ready;
    logic [rrd_pkg::BYTE_W-1:0]  ring_byte;

    modport source (output valid, output ring_byte, input ready);
    modport sink (input valid, input ring_byte, output ready);
endinterface

interface rrd_frame_if;
    logic                        valid;
    logic                        ready;
    logic [rrd_pkg::BYTE_W-1:0]  frame_byte;
    logic                        byte_valid;
    logic                        frame_last;
    logic                        status_ok;
    logic                        size_error;
    logic [rrd_pkg::REL_W-1:0]   release_offset;

    modport source (output valid, output frame_byte, output byte_valid, output frame_last,
                    output status_ok, output size_error, output release_offset,
                    input ready);
    modport sink (input valid, input frame_byte, input byte_valid, input frame_last,
                  input status_ok, input size_error, input release_offset,
                  output ready);
endinterface

// ===== rtl/rx_ring_record_deframer.sv =====
// Receive ring deframer.
// The ring channel carries one ring byte per transfer, in ring order. While
// receive_enable is set, each byte is parsed: a 4-byte little-endian header
// (status word, then size counting frame plus CRC), size-4 frame bytes, then
// the CRC and padding up to the next 4-byte boundary, which are dropped.
// The frame channel carries one transfer per frame byte; the final transfer
// of a record has frame_last, status_ok and release_offset (next record start
// minus 16, 13 bits). An empty frame yields one end marker with byte_valid
// low. A size below 4 or above max_record_len yields one size_error transfer,
// after which every byte is dropped until reset.
// Results are registered in the output buffer. The block takes one ring byte
// every cycle while that buffer has room; all parsing for a byte is done
// in the cycle it is taken. A two-entry output buffer keeps the ring side
// moving while a result waits; ring.ready falls only when both entries are
// held by a stalled receiver. Configuration writes take effect at the next
// cycle. Reset disables receive, restores the limit to 1600 and returns the
// parser to the start of a record at ring offset zero; no clearing pass runs.
module rx_ring_record_deframer #(
    parameter int RING_BYTES = rrd_pkg::RING_BYTES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rrd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rrd_pkg::CFG_DATA_W-1:0]  cfg_data,
    rrd_ring_if.sink                        ring,
    rrd_frame_if.source                     frame
);
    import rrd_pkg::*;

    logic         in_fire;
    logic         push;
    logic         room;
    rrd_result_t  result;
    rrd_result_t  head;

    assign in_fire    = ring.valid && ring.ready;
    assign ring.ready = room;

    // Header, count and offset logic for each accepted byte.
    rrd_parser #(
        .RING_BYTES (RING_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_fire   (in_fire),
        .in_byte   (ring.ring_byte),
        .push      (push),
        .result    (result)
    );

    // Result register plus skid entry toward the frame receiver.
    rrd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (result),
        .room      (room),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .dout      (head)
    );

    assign frame.frame_byte     = head.frame_byte;
    assign frame.byte_valid     = head.byte_valid;
    assign frame.frame_last     = head.frame_last;
    assign frame.status_ok      = head.status_ok;
    assign frame.size_error     = head.size_error;
    assign frame.release_offset = head.release_offset;

endmodule

// ===== rtl/rrd_parser.sv =====
module rrd_parser #(
    parameter int RING_BYTES = rrd_pkg::RING_BYTES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rrd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_fire,
    input  logic [rrd_pkg::BYTE_W-1:0]       in_byte,
    output logic                             push,
    output rrd_pkg::rrd_result_t             result
);
    import rrd_pkg::*;

    localparam int OW = $clog2(RING_BYTES);
    localparam int EW = $clog2(RING_BYTES + MAX_SPAN_PAD);
    localparam logic [EW-1:0] RING_E = EW'(RING_BYTES);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA   = 2'd1;
    localparam logic [1:0] PH_SKIP   = 2'd2;
    localparam logic [1:0] PH_HALT   = 2'd3;

    logic               enable_reg, enable_next;
    logic [LEN_W-1:0]   max_len_reg, max_len_next;
    logic [1:0]         phase_reg, phase_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               status_ok_reg, status_ok_next;
    logic [BYTE_W-1:0]  size_lo_reg, size_lo_next;
    logic [LEN_W-1:0]   rec_size_reg, rec_size_next;
    logic [CNT_W-1:0]   span_reg, span_next;
    logic [OW-1:0]      read_off_reg, read_off_next;
    logic [EW-1:0]      next_off_reg, next_off_next;

    logic [2*BYTE_W-1:0] hdr_size;
    logic                size_bad;
    logic [EW-1:0]       end_sum;
    logic [EW-1:0]       end_aligned;
    logic [CNT_W-1:0]    hdr_span;
    logic [CNT_W-1:0]    count_inc;
    logic [EW-1:0]       hdr_wrapped;
    logic [EW-1:0]       next_off_wrapped;
    logic                work;

    // One conditional subtract of the ring size; the stored next offset is
    // brought below the ring size a step per cycle well before it is used.
    function automatic logic [EW-1:0] wrap_once(input logic [EW-1:0] v);
        return (v >= RING_E) ? v - RING_E : v;
    endfunction

    function automatic logic [REL_W-1:0] release_of(input logic [EW-1:0] off);
        logic [REL_W-1:0] low;
        low = REL_W'(off);
        return low - REL_W'(REL_BACKOFF);
    endfunction

    assign hdr_size         = {in_byte, size_lo_reg};
    assign size_bad         = (hdr_size < 16'(HDR_LEN)) || (hdr_size > 16'(max_len_reg));
    assign end_sum          = EW'(read_off_reg) + EW'(hdr_size[LEN_W-1:0]) + EW'(HDR_LEN + 3);
    assign end_aligned      = {end_sum[EW-1:2], 2'b00};
    assign hdr_span         = CNT_W'(end_aligned - EW'(read_off_reg));
    assign count_inc        = count_reg + CNT_W'(1);
    assign hdr_wrapped      = wrap_once(end_aligned);
    assign next_off_wrapped = wrap_once(next_off_reg);
    assign work             = in_fire && enable_reg && (phase_reg != PH_HALT);

    always_comb
    begin
        enable_next    = enable_reg;
        max_len_next   = max_len_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        status_ok_next = status_ok_reg;
        size_lo_next   = size_lo_reg;
        rec_size_next  = rec_size_reg;
        span_next      = span_reg;
        read_off_next  = read_off_reg;
        next_off_next  = next_off_wrapped;
        push           = 1'b0;
        result         = '0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RECEIVE_ENABLE: enable_next  = cfg_data[0];
                REG_MAX_RECORD_LEN: max_len_next = cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end

        if (work)
        begin
            count_next = count_inc;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    unique case (count_reg[1:0])
                        2'd0: status_ok_next = in_byte[0];
                        2'd1: ;
                        2'd2: size_lo_next = in_byte;
                        2'd3:
                        begin
                            if (size_bad)
                            begin
                                push              = 1'b1;
                                result.size_error = 1'b1;
                                phase_next        = PH_HALT;
                            end
                            else
                            begin
                                rec_size_next = hdr_size[LEN_W-1:0];
                                span_next     = hdr_span;
                                next_off_next = hdr_wrapped;
                                if (hdr_size == 16'(HDR_LEN))
                                begin
                                    // Empty frame: a single end marker.
                                    push                  = 1'b1;
                                    result.frame_last     = 1'b1;
                                    result.status_ok      = status_ok_reg;
                                    result.release_offset = release_of(hdr_wrapped);
                                    phase_next            = PH_SKIP;
                                end
                                else
                                begin
                                    phase_next = PH_DATA;
                                end
                            end
                        end
                    endcase
                end
                PH_DATA:
                begin
                    push              = 1'b1;
                    result.frame_byte = in_byte;
                    result.byte_valid = 1'b1;
                    if (count_inc == CNT_W'(rec_size_reg))
                    begin
                        result.frame_last     = 1'b1;
                        result.status_ok      = status_ok_reg;
                        result.release_offset = release_of(next_off_wrapped);
                        phase_next            = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (count_inc >= span_reg)
                    begin
                        read_off_next  = OW'(next_off_wrapped);
                        count_next     = '0;
                        status_ok_next = 1'b0;
                        phase_next     = PH_HEADER;
                    end
                end
                PH_HALT: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            max_len_reg   <= MAX_LEN_RESET;
            phase_reg     <= PH_HEADER;
            count_reg     <= '0;
            status_ok_reg <= 1'b0;
            size_lo_reg   <= '0;
            rec_size_reg  <= '0;
            span_reg      <= '0;
            read_off_reg  <= '0;
            next_off_reg  <= '0;
        end
        else
        begin
            enable_reg    <= enable_next;
            max_len_reg   <= max_len_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            status_ok_reg <= status_ok_next;
            size_lo_reg   <= size_lo_next;
            rec_size_reg  <= rec_size_next;
            span_reg      <= span_next;
            read_off_reg  <= read_off_next;
            next_off_reg  <= next_off_next;
        end
    end

endmodule

// ===== rtl/rrd_outq.sv =====
module rrd_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rrd_pkg::rrd_result_t  din,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rrd_pkg::rrd_result_t  dout
);
    import rrd_pkg::*;

    logic [1:0]   count_reg, count_next;
    rrd_result_t  q0_reg, q0_next;
    rrd_result_t  q1_reg, q1_next;
    logic         pop;

    assign room      = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign dout      = q0_reg;

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        if (pop)
        begin
            q0_next = q1_reg;
        end
        if (push)
        begin
            if ((count_reg == 2'd0) || ((count_reg == 2'd1) && pop))
            begin
                q0_next = din;
            end
            else
            begin
                q1_next = din;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

// ===== rtl/rrd_checker.sv =====
module rrd_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         frame_valid,
    input  logic                         frame_ready,
    input  logic [rrd_pkg::BYTE_W-1:0]   frame_byte,
    input  logic                         byte_valid,
    input  logic                         frame_last,
    input  logic                         status_ok,
    input  logic                         size_error,
    input  logic [rrd_pkg::REL_W-1:0]    release_offset
);
    logic err_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_seen_reg <= 1'b0;
        end
        else if (frame_valid && frame_ready && size_error)
        begin
            err_seen_reg <= 1'b1;
        end
    end

    // A stalled result holds its contents.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid &&
        $stable({frame_byte, byte_valid, frame_last, status_ok, size_error, release_offset}))
        else $error("frame result changed while stalled");

    // An error result carries nothing else.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && size_error |-> !byte_valid && !frame_last && !status_ok &&
        frame_byte == 8'd0 && release_offset == 13'd0)
        else $error("size error result carries other fields");

    // Status and release offset appear only with the end of a record.
    a_mid_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_last |-> !status_ok && release_offset == 13'd0)
        else $error("status or release offset outside record end");

    // A result without data that is not an error is an empty-frame marker.
    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !byte_valid && !size_error |-> frame_last && frame_byte == 8'd0)
        else $error("malformed empty frame marker");

    // After the error transfer the block produces nothing until reset.
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        err_seen_reg |-> !frame_valid)
        else $error("result after size error");

endmodule

bind rx_ring_record_deframer rrd_checker u_rrd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .frame_valid    (frame.valid),
    .frame_ready    (frame.ready),
    .frame_byte     (frame.frame_byte),
    .byte_valid     (frame.byte_valid),
    .frame_last     (frame.frame_last),
    .status_ok      (frame.status_ok),
    .size_error     (frame.size_error),
    .release_offset (frame.release_offset)
);
